@@ hdl/svfl_pkg.sv @@
package svfl_pkg;

   // Coefficient format: unsigned Q.23 in 24 bits
   localparam int COEF_BITS = 24;
   localparam int COEF_FRAC = 23;

   // Configuration register indexes
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_G1 = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_G2 = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_G3 = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_G4 = 2'd3;

   typedef struct packed {
      logic [COEF_BITS-1:0] g1;
      logic [COEF_BITS-1:0] g2;
      logic [COEF_BITS-1:0] g3;
      logic [COEF_BITS-1:0] g4;
   } coef_type;

endpackage

@@ hdl/svf_lowpass_trapezoidal_top.sv @@
// Second-order trapezoidal state-variable low-pass filter.
// Input stream (req_*): one signed sample per item in the low SAMPLE_BITS
// of req_tdata. Result stream (rsp_*): one low-pass sample per input item,
// sign bits in the low SAMPLE_BITS of rsp_tdata, upper pad bits zero.
// Coefficients g1..g4 (unsigned Q.23) are written through csr_we/csr_addr/
// csr_wdata, indexes 0..3; the user must write them only while no item is in flight, which the block does not enforce.
// An accepted item is registered in the input register; its result is
// loaded into the output register on step and from there shows on rsp_tvalid.
// Throughput: one item per cycle while rsp_tready stays high; the whole filter update
// (four coefficient multiplies, sums, saturation) sits between the input
// register and the output register, and the integrator feedback closes within it.
// Reset (synchronous, active high) clears the coefficients, both integrator
// states, the previous sample and both valid flags.
// When the receiver stalls, the output register holds its item and the input
// register can still take one more item; beyond that req_tready drops.
module svf_lowpass_trapezoidal_top #(
   parameter int SAMPLE_BITS = 24,
   parameter int STATE_BITS  = 28
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,  // [SAMPLE_BITS-1:0] sample_in
   // result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata,  // [SAMPLE_BITS-1:0] lowpass_out
   // configuration writes
   input  logic                                   csr_we,
   input  logic [svfl_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [svfl_pkg::COEF_BITS-1:0]         csr_wdata
);
   import svfl_pkg::*;

   localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

   coef_type coef_ff;

   logic                          in_valid_ff;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;
   logic signed [SAMPLE_BITS-1:0] lowpass;
   logic                          advance;
   logic                          step;

   // output register free or being emptied this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'($unsigned(rsp_data_ff));

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_G1:  coef_ff.g1 <= csr_wdata;
            REG_G2:  coef_ff.g2 <= csr_wdata;
            REG_G3:  coef_ff.g3 <= csr_wdata;
            REG_G4:  coef_ff.g4 <= csr_wdata;
            default: coef_ff <= coef_ff;
         endcase
      end
   end

   // input register: take a new item when empty or whenever the current one moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sample_ff <= $signed(req_tdata[SAMPLE_BITS-1:0]);
      end
   end

   svfl_datapath #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .STATE_BITS (STATE_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .sample (in_sample_ff),
      .coefs  (coef_ff),
      .lowpass(lowpass)
   );

   // output register: load on step, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= lowpass;
      end
   end

endmodule

@@ hdl/svfl_datapath.sv @@
module svfl_datapath #(
   parameter int SAMPLE_BITS = 24,
   parameter int STATE_BITS  = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  svfl_pkg::coef_type            coefs,
   output logic signed [SAMPLE_BITS-1:0] lowpass
);
   import svfl_pkg::*;

   localparam int MAXB = (SAMPLE_BITS > STATE_BITS) ? SAMPLE_BITS : STATE_BITS;
   localparam int VW   = MAXB + 2;
   localparam int PW   = VW + COEF_BITS + 1;
   localparam int SW   = PW + 2;
   localparam int OW   = MAXB + 1;

   localparam logic signed [PW-1:0] RND    = PW'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [SW-1:0] ST_MAX = (SW'(1) <<< (STATE_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0] ST_MIN = -ST_MAX - SW'(1);
   localparam logic signed [OW-1:0] SP_MAX = (OW'(1) <<< (SAMPLE_BITS - 1)) - OW'(1);
   localparam logic signed [OW-1:0] SP_MIN = -SP_MAX - OW'(1);

   logic signed [STATE_BITS-1:0]  band_ff, band_in;
   logic signed [STATE_BITS-1:0]  low_ff, low_in;
   logic signed [SAMPLE_BITS-1:0] prev_ff;

   logic signed [COEF_BITS:0] g1s, g2s, g3s, g4s;
   logic signed [VW-1:0]      v3;
   logic signed [PW-1:0]      p1, p2, p3, p4;
   logic signed [PW-1:0]      r1, r2, r3, r4;
   logic signed [SW-1:0]      nb, nl;
   logic signed [OW-1:0]      low_ext;

   assign g1s = {1'b0, coefs.g1};
   assign g2s = {1'b0, coefs.g2};
   assign g3s = {1'b0, coefs.g3};
   assign g4s = {1'b0, coefs.g4};

   always_comb begin
      v3 = VW'(sample) + VW'(prev_ff) - (VW'(low_ff) <<< 1);

      p1 = PW'(g1s) * PW'(v3);
      p2 = PW'(g2s) * PW'(band_ff);
      p3 = PW'(g3s) * PW'(v3);
      p4 = PW'(g4s) * PW'(band_ff);

      // round half up, then drop the fraction bits
      r1 = (p1 + RND) >>> COEF_FRAC;
      r2 = (p2 + RND) >>> COEF_FRAC;
      r3 = (p3 + RND) >>> COEF_FRAC;
      r4 = (p4 + RND) >>> COEF_FRAC;

      nb = SW'(band_ff) + SW'(r1) - SW'(r2);
      nl = SW'(low_ff) + SW'(r3) + SW'(r4);

      if (nb > ST_MAX) begin
         band_in = ST_MAX[STATE_BITS-1:0];
      end else if (nb < ST_MIN) begin
         band_in = ST_MIN[STATE_BITS-1:0];
      end else begin
         band_in = nb[STATE_BITS-1:0];
      end

      if (nl > ST_MAX) begin
         low_in = ST_MAX[STATE_BITS-1:0];
      end else if (nl < ST_MIN) begin
         low_in = ST_MIN[STATE_BITS-1:0];
      end else begin
         low_in = nl[STATE_BITS-1:0];
      end

      low_ext = OW'(low_in);
      if (low_ext > SP_MAX) begin
         lowpass = SP_MAX[SAMPLE_BITS-1:0];
      end else if (low_ext < SP_MIN) begin
         lowpass = SP_MIN[SAMPLE_BITS-1:0];
      end else begin
         lowpass = low_ext[SAMPLE_BITS-1:0];
      end
   end

   // advance the integrators once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
         low_ff  <= '0;
         prev_ff <= '0;
      end else if (step) begin
         band_ff <= band_in;
         low_ff  <= low_in;
         prev_ff <= sample;
      end
   end

endmodule
